>>> rtl/urs_pkg.sv
// Shared types and constants for the uniform rejection sampler.
`timescale 1ns / 1ps

package urs_pkg;

    localparam int unsigned MAX_COEFFS = 256;

    localparam int unsigned CFG_WIDTH   = 13;
    localparam int unsigned MOD_WIDTH   = 13;
    localparam int unsigned COUNT_WIDTH = 9;
    localparam int unsigned COEFF_WIDTH = 12;
    localparam int unsigned INDEX_WIDTH = 8;

    localparam logic [12:0] MODULUS_RESET     = 13'd3329;
    localparam logic [8:0]  COEFF_COUNT_RESET = 9'd256;
    localparam logic [11:0] CAND_MASK         = 12'hFFF;

    // configuration register indices
    localparam logic REG_MODULUS     = 1'b0;
    localparam logic REG_COEFF_COUNT = 1'b1;

    // position of the next byte within its triple
    typedef enum logic [1:0] {
        PH_B0 = 2'd0,
        PH_B1 = 2'd1,
        PH_B2 = 2'd2
    } phase_t;

    typedef struct packed {
        logic [COEFF_WIDTH-1:0] coeff;
        logic [INDEX_WIDTH-1:0] coeff_index;
        logic                   last;
    } result_t;

endpackage

>>> rtl/uniform_rejection_sampler.sv
// Top level of the uniform rejection sampler.
`timescale 1ns / 1ps

// Takes one random byte per item and turns each byte triple into two 12-bit
// candidates; a candidate below the modulus leaves as the next coefficient
// with its index and a last flag, until the configured count is reached.
// Sustained rate is one byte per clock: the candidate test and count update are
// a single compare-and-increment between the phase/count registers and the
// result register. Results leave through an output register backed by one skid
// entry, so input is stalled only when both are full. new_poly on an item restarts
// the count and the triple alignment before that byte is used. The user must
// write configuration (modulus, coefficient count) only while idle, unenforced.
module uniform_rejection_sampler
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [urs_pkg::CFG_WIDTH-1:0]     cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        rand_byte,
    input  logic                              new_poly,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [urs_pkg::COEFF_WIDTH-1:0]   coeff,
    output logic [urs_pkg::INDEX_WIDTH-1:0]   coeff_index,
    output logic                              last
);

    localparam logic [10:0] MAX_W = 11'(urs_pkg::MAX_COEFFS);

    logic [urs_pkg::MOD_WIDTH-1:0]   modulus_reg;
    logic [urs_pkg::COUNT_WIDTH-1:0] coeff_count_reg;

    urs_pkg::phase_t                 phase_reg, phase_next, phase_eff;
    logic [7:0]                      held_reg, held_next;
    logic [urs_pkg::COUNT_WIDTH-1:0] count_reg, count_next, count_eff;

    urs_pkg::result_t                out_reg, skid_reg, res;
    logic                            out_valid_reg, skid_valid_reg;

    logic [urs_pkg::COUNT_WIDTH-1:0] limit;
    logic [urs_pkg::COUNT_WIDTH-1:0] count_inc;
    logic [urs_pkg::COEFF_WIDTH-1:0] cand;
    logic                            offer;
    logic                            res_valid;
    logic                            in_fire;
    logic                            out_fire;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;

    assign coeff       = out_reg.coeff;
    assign coeff_index = out_reg.coeff_index;
    assign last        = out_reg.last;

    // limit is the smaller of the configured count and the build maximum
    assign limit = ({2'b00, coeff_count_reg} > MAX_W) ? MAX_W[8:0] : coeff_count_reg;

    assign phase_eff = new_poly ? urs_pkg::PH_B0 : phase_reg;
    assign count_eff = new_poly ? '0 : count_reg;
    assign count_inc = count_eff + 9'd1;

    always_comb
    begin
        offer      = 1'b0;
        cand       = '0;
        phase_next = urs_pkg::PH_B1;
        held_next  = rand_byte;
        unique case (phase_eff)
            urs_pkg::PH_B1:
            begin
                offer      = 1'b1;
                cand       = {rand_byte[3:0], held_reg} & urs_pkg::CAND_MASK;
                phase_next = urs_pkg::PH_B2;
                held_next  = {4'h0, rand_byte[7:4]};
            end
            urs_pkg::PH_B2:
            begin
                offer      = 1'b1;
                cand       = {rand_byte, held_reg[3:0]} & urs_pkg::CAND_MASK;
                phase_next = urs_pkg::PH_B0;
                held_next  = '0;
            end
            default:
            begin
                // first byte of a triple, also the unused phase code
                offer      = 1'b0;
                cand       = '0;
                phase_next = urs_pkg::PH_B1;
                held_next  = rand_byte;
            end
        endcase
    end

    assign res_valid = in_fire && offer && (count_eff < limit)
                       && ({1'b0, cand} < modulus_reg);
    assign count_next = res_valid ? count_inc : count_eff;

    assign res.coeff       = cand;
    assign res.coeff_index = count_eff[urs_pkg::INDEX_WIDTH-1:0];
    assign res.last        = (count_inc == limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= urs_pkg::MODULUS_RESET;
            coeff_count_reg <= urs_pkg::COEFF_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                urs_pkg::REG_MODULUS:     modulus_reg     <= cfg_data;
                urs_pkg::REG_COEFF_COUNT: coeff_count_reg <= cfg_data[8:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= urs_pkg::PH_B0;
            held_reg  <= '0;
            count_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (res_valid)
            begin
                out_reg <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

endmodule

>>> rtl/urs_checker.sv
// Port-level checks for the uniform rejection sampler, bound to the top level.
`timescale 1ns / 1ps

module urs_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [urs_pkg::COEFF_WIDTH-1:0] coeff,
    input logic [urs_pkg::INDEX_WIDTH-1:0] coeff_index,
    input logic                            last
);

    // input is only held off while a result is waiting at the output
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // a held-off output keeps the skid entry occupied
    a_stall_persists: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && out_stall) |=> in_stall)
        else $error("skid entry lost while output stalled");

    // once the output moves, the skid entry is empty in the next cycle
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && !out_stall) |=> !in_stall)
        else $error("skid entry did not drain");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(coeff)
                                      && $stable(coeff_index) && $stable(last)))
        else $error("stalled result changed");

endmodule

bind uniform_rejection_sampler urs_checker u_urs_checker (.*);
